// File: sv/cio_pkg.sv
// Package for the console I/O register page: request codes, register offsets
// and the packed transaction types. No dependencies.
`timescale 1ns / 1ps
package cio_pkg;

	localparam int DMA_CHANNELS_DEF = 8;

	localparam logic [2:0] REQ_WRITE = 3'd0;
	localparam logic [2:0] REQ_READ  = 3'd1;
	localparam logic [2:0] REQ_NMI   = 3'd2;
	localparam logic [2:0] REQ_IRQ   = 3'd3;
	localparam logic [2:0] REQ_JOY   = 3'd4;

	localparam logic [8:0] A_NMITIMEN = 9'h000;
	localparam logic [8:0] A_WRMPYA   = 9'h002;
	localparam logic [8:0] A_WRMPYB   = 9'h003;
	localparam logic [8:0] A_WRDIVL   = 9'h004;
	localparam logic [8:0] A_WRDIVH   = 9'h005;
	localparam logic [8:0] A_WRDIVB   = 9'h006;
	localparam logic [8:0] A_HTIMEL   = 9'h007;
	localparam logic [8:0] A_HTIMEH   = 9'h008;
	localparam logic [8:0] A_VTIMEL   = 9'h009;
	localparam logic [8:0] A_VTIMEH   = 9'h00A;
	localparam logic [8:0] A_MDMAEN   = 9'h00B;
	localparam logic [8:0] A_HDMAEN   = 9'h00C;
	localparam logic [8:0] A_RDNMI    = 9'h010;
	localparam logic [8:0] A_TIMEUP   = 9'h011;
	localparam logic [8:0] A_HVBJOY   = 9'h012;
	localparam logic [8:0] A_RDDIVL   = 9'h014;
	localparam logic [8:0] A_RDDIVH   = 9'h015;
	localparam logic [8:0] A_RDMPYL   = 9'h016;
	localparam logic [8:0] A_RDMPYH   = 9'h017;
	localparam logic [8:0] A_JOYL     = 9'h018;
	localparam logic [8:0] A_JOYH     = 9'h019;

	localparam logic [3:0] R_CTRL  = 4'h0;
	localparam logic [3:0] R_DEST  = 4'h1;
	localparam logic [3:0] R_SRCL  = 4'h2;
	localparam logic [3:0] R_SRCH  = 4'h3;
	localparam logic [3:0] R_BANK  = 4'h4;
	localparam logic [3:0] R_LENL  = 4'h5;
	localparam logic [3:0] R_LENH  = 4'h6;
	localparam logic [3:0] R_IBANK = 4'h7;
	localparam logic [3:0] R_TABL  = 4'h8;
	localparam logic [3:0] R_TABH  = 4'h9;
	localparam logic [3:0] R_LINES = 4'hA;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [8:0]  reg_addr;
		logic [7:0]  write_data;
		logic        vblank;
		logic        joy_busy;
		logic        early_in_line;
		logic [15:0] joy_word;
	} cio_req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       nmi_enable_out;
		logic [1:0] irq_mode_out;
		logic       irq_pending;
		logic [8:0] h_irq_pos_out;
		logic [8:0] v_irq_pos_out;
		logic [7:0] hdma_mask_out;
	} cio_rsp_t;

endpackage

// File: sv/console_io_math_dma_registers_top.sv
// Console I/O register page: IRQ/NMI control, multiply/divide, DMA channel set.
// Depends on cio_pkg.
`timescale 1ns / 1ps
// One transaction is taken when start is high and busy is low; its result is
// shown for one cycle with done high and cannot be stalled. Most transactions
// go from ST_EXEC straight to ST_DONE (accept, then result). A write to
// WRDIVB with a nonzero divisor runs the shared 17-bit subtractor one
// restoring step per cycle. A DMA enable write uses the same adder, visiting
// one channel per cycle. A write to WRMPYB runs one shift-add step per cycle.
module console_io_math_dma_registers_top #(
	parameter int DMA_CHANNELS = cio_pkg::DMA_CHANNELS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  cio_pkg::cio_req_t req,
	output logic              busy,
	output logic              done,
	output cio_pkg::cio_rsp_t rsp
);
	import cio_pkg::*;

	localparam int CW = (DMA_CHANNELS > 1) ? $clog2(DMA_CHANNELS) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_DMA  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]  state_q;
	cio_req_t    req_q;
	logic [4:0]  cnt_q;
	logic [7:0]  rd_q;

	logic        nmi_enable_q, nmi_flag_q, irq_flag_q;
	logic [1:0]  irq_mode_q;
	logic [8:0]  h_irq_pos_q, v_irq_pos_q;
	logic [7:0]  hdma_mask_q, multiplicand_q;
	logic [15:0] prod_rem_q, dividend_q, quotient_q, joypad_q;

	logic [7:0]  ch_ctrl_q  [DMA_CHANNELS];
	logic [7:0]  ch_dest_q  [DMA_CHANNELS];
	logic [15:0] ch_src_q   [DMA_CHANNELS];
	logic [7:0]  ch_bank_q  [DMA_CHANNELS];
	logic [15:0] ch_len_q   [DMA_CHANNELS];
	logic [7:0]  ch_ibank_q [DMA_CHANNELS];
	logic [15:0] ch_tab_q   [DMA_CHANNELS];
	logic [7:0]  ch_lines_q [DMA_CHANNELS];

	// shared unit operands
	logic [16:0] alu_a, alu_b, alu_y;
	logic        alu_sub;

	// channel decode
	logic [2:0]  ch_raw;
	logic [3:0]  ch_reg;
	logic        ch_ok;
	logic [CW-1:0] ch_idx, dma_idx;
	assign ch_raw = req_q.reg_addr[6:4];
	assign ch_reg = req_q.reg_addr[3:0];
	assign ch_ok  = req_q.reg_addr[8] && !req_q.reg_addr[7] && (32'(ch_raw) < DMA_CHANNELS);
	assign ch_idx = CW'(ch_raw);
	assign dma_idx = CW'(cnt_q);

	// divide step: partial remainder in prod_rem_q, quotient bits shift in
	logic [16:0] div_trial;
	assign div_trial = {prod_rem_q, quotient_q[15]};

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		case (state_q)
			ST_MUL: begin
				alu_a = {1'b0, prod_rem_q};
				alu_b = {9'd0, multiplicand_q} << cnt_q[2:0];
			end
			ST_DIV: begin
				alu_a   = div_trial;
				alu_b   = {1'b0, req_q.write_data, 8'd0} >> 8;
				alu_sub = 1'b1;
			end
			ST_DMA: begin
				alu_a   = {1'b0, ch_src_q[dma_idx]};
				alu_b   = {1'b0, ch_len_q[dma_idx]};
				alu_sub = ch_ctrl_q[dma_idx][4];
			end
			default: ;
		endcase
		alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
	end

	// read mux
	logic [7:0] rd_val;
	always_comb begin
		rd_val = '0;
		if (req_q.reg_addr[8]) begin
			if (ch_ok) begin
				case (ch_reg)
					R_CTRL:  rd_val = ch_ctrl_q[ch_idx];
					R_DEST:  rd_val = ch_dest_q[ch_idx];
					R_SRCL:  rd_val = ch_src_q[ch_idx][7:0];
					R_SRCH:  rd_val = ch_src_q[ch_idx][15:8];
					R_BANK:  rd_val = ch_bank_q[ch_idx];
					R_LENL:  rd_val = ch_len_q[ch_idx][7:0];
					R_LENH:  rd_val = ch_len_q[ch_idx][15:8];
					R_IBANK: rd_val = ch_ibank_q[ch_idx];
					default: rd_val = '0;
				endcase
			end
		end else begin
			case (req_q.reg_addr)
				A_HDMAEN: rd_val = hdma_mask_q;
				A_RDNMI:  rd_val = {nmi_flag_q, 7'd0};
				A_TIMEUP: rd_val = {irq_flag_q, 7'd0};
				A_HVBJOY: rd_val = {req_q.vblank, req_q.early_in_line, 5'd0, req_q.joy_busy};
				A_RDDIVL: rd_val = quotient_q[7:0];
				A_RDDIVH: rd_val = quotient_q[15:8];
				A_RDMPYL: rd_val = prod_rem_q[7:0];
				A_RDMPYH: rd_val = prod_rem_q[15:8];
				A_JOYL:   rd_val = joypad_q[7:0];
				A_JOYH:   rd_val = joypad_q[15:8];
				default:  rd_val = '0;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

	// sequencer and register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			rd_q           <= '0;
			nmi_enable_q   <= 1'b0;
			nmi_flag_q     <= 1'b0;
			irq_flag_q     <= 1'b0;
			irq_mode_q     <= '0;
			h_irq_pos_q    <= '0;
			v_irq_pos_q    <= '0;
			hdma_mask_q    <= '0;
			multiplicand_q <= '0;
			prod_rem_q     <= '0;
			dividend_q     <= '0;
			quotient_q     <= '0;
			joypad_q       <= '0;
			for (int i = 0; i < DMA_CHANNELS; i++) begin
				ch_ctrl_q[i]  <= '0;
				ch_dest_q[i]  <= '0;
				ch_src_q[i]   <= '0;
				ch_bank_q[i]  <= '0;
				ch_len_q[i]   <= '0;
				ch_ibank_q[i] <= '0;
				ch_tab_q[i]   <= '0;
				ch_lines_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						req_q   <= req;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					rd_q    <= '0;
					cnt_q   <= '0;
					state_q <= ST_DONE;
					case (req_q.req_type)
						REQ_NMI: nmi_flag_q <= 1'b1;
						REQ_IRQ: irq_flag_q <= 1'b1;
						REQ_JOY: joypad_q <= req_q.joy_word;
						REQ_READ: begin
							rd_q <= rd_val;
							if (req_q.reg_addr == A_RDNMI) nmi_flag_q <= 1'b0;
							if (req_q.reg_addr == A_TIMEUP) irq_flag_q <= 1'b0;
						end
						REQ_WRITE: begin
							if (req_q.reg_addr[8]) begin
								if (ch_ok) begin
									case (ch_reg)
										R_CTRL:  ch_ctrl_q[ch_idx] <= req_q.write_data;
										R_DEST:  ch_dest_q[ch_idx] <= req_q.write_data;
										R_SRCL:  ch_src_q[ch_idx][7:0] <= req_q.write_data;
										R_SRCH:  ch_src_q[ch_idx][15:8] <= req_q.write_data;
										R_BANK:  ch_bank_q[ch_idx] <= req_q.write_data;
										R_LENL:  ch_len_q[ch_idx][7:0] <= req_q.write_data;
										R_LENH:  ch_len_q[ch_idx][15:8] <= req_q.write_data;
										R_IBANK: ch_ibank_q[ch_idx] <= req_q.write_data;
										R_TABL:  ch_tab_q[ch_idx][7:0] <= req_q.write_data;
										R_TABH:  ch_tab_q[ch_idx][15:8] <= req_q.write_data;
										R_LINES: ch_lines_q[ch_idx] <= req_q.write_data;
										default: ;
									endcase
								end
							end else begin
								case (req_q.reg_addr)
									A_NMITIMEN: begin
										nmi_enable_q <= req_q.write_data[7];
										irq_mode_q   <= req_q.write_data[5:4];
										if (req_q.write_data[5:4] == 2'd0) irq_flag_q <= 1'b0;
									end
									A_WRMPYA: multiplicand_q <= req_q.write_data;
									A_WRMPYB: begin
										prod_rem_q <= '0;
										state_q    <= ST_MUL;
									end
									A_WRDIVL: dividend_q[7:0] <= req_q.write_data;
									A_WRDIVH: dividend_q[15:8] <= req_q.write_data;
									A_WRDIVB: begin
										if (req_q.write_data == 8'd0) begin
											quotient_q <= 16'hFFFF;
											prod_rem_q <= dividend_q;
										end else begin
											quotient_q <= dividend_q;
											prod_rem_q <= '0;
											state_q    <= ST_DIV;
										end
									end
									A_HTIMEL: h_irq_pos_q[7:0] <= req_q.write_data;
									A_HTIMEH: h_irq_pos_q[8] <= req_q.write_data[0];
									A_VTIMEL: v_irq_pos_q[7:0] <= req_q.write_data;
									A_VTIMEH: v_irq_pos_q[8] <= req_q.write_data[0];
									A_MDMAEN: state_q <= ST_DMA;
									A_HDMAEN: hdma_mask_q <= req_q.write_data;
									default: ;
								endcase
							end
						end
						default: ;
					endcase
				end
				// shift-add: add multiplicand<<i when multiplier bit i is set
				ST_MUL: begin
					if (req_q.write_data[cnt_q[2:0]]) prod_rem_q <= alu_y[15:0];
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd7) state_q <= ST_DONE;
				end
				// restoring divide, one quotient bit per cycle
				ST_DIV: begin
					if (!alu_y[16]) prod_rem_q <= alu_y[15:0];
					else prod_rem_q <= div_trial[15:0];
					quotient_q <= {quotient_q[14:0], ~alu_y[16]};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd15) state_q <= ST_DONE;
				end
				// one channel per cycle through the shared adder
				ST_DMA: begin
					if (req_q.write_data[cnt_q[2:0]]) begin
						if (!ch_ctrl_q[dma_idx][3]) ch_src_q[dma_idx] <= alu_y[15:0];
						ch_len_q[dma_idx] <= '0;
					end
					cnt_q <= cnt_q + 5'd1;
					if (32'(cnt_q) == DMA_CHANNELS - 1) state_q <= ST_DONE;
				end
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		rsp.read_data      = rd_q;
		rsp.nmi_enable_out = nmi_enable_q;
		rsp.irq_mode_out   = irq_mode_q;
		rsp.irq_pending    = irq_flag_q;
		rsp.h_irq_pos_out  = h_irq_pos_q;
		rsp.v_irq_pos_out  = v_irq_pos_q;
		rsp.hdma_mask_out  = hdma_mask_q;
	end

`ifndef NO_ASSERTIONS
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("done not followed by idle");
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == ST_EXEC)) else $error("accept lost");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q < 5'd16)) else $error("divide overran");
	a_mode_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(done && irq_mode_q == 2'd0 && $past(state_q == ST_EXEC)
		 && req_q.req_type == REQ_WRITE && req_q.reg_addr == A_NMITIMEN) |-> !irq_flag_q)
		else $error("irq flag survived mode 0");
`endif

endmodule
